// ===== hdl/tmvc_pkg.sv =====
package tmvc_pkg;

  // Vertex memory geometry and coordinate format.
  localparam int unsigned VERTEX_DEPTH = 65536;
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int unsigned VERT_W       = 3 * COORD_BITS;

  // Fixed port widths.
  localparam int unsigned IN_COORD_W = 24;
  localparam int unsigned CORNER_W   = 32;
  localparam int unsigned SLOT_W     = 16;
  localparam int unsigned TALLY_W    = 32;
  localparam int unsigned VCOUNT_W   = 17;
  localparam int unsigned LIMIT_W    = 62;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 62;

  // Arithmetic widths. A minor is split into an unsigned low part and a
  // signed high part so that every product fits the one shared multiplier.
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned MINOR_W = 2 * DIFF_W + 1;
  localparam int unsigned LO_W    = MINOR_W - DIFF_W;
  localparam int unsigned OPA_W   = LO_W + 1;
  localparam int unsigned PROD_W  = OPA_W + DIFF_W;
  localparam int unsigned VOL_W   = PROD_W + LO_W;
  localparam int unsigned CMP_W   = (VOL_W > LIMIT_W) ? VOL_W : LIMIT_W;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    CLS_OK    = 2'd0,
    CLS_DEGEN = 2'd1,
    CLS_INV   = 2'd2,
    CLS_BAD   = 2'd3
  } tet_class_e;

  // Multiplier schedule: six minor products, then six partial volume products.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_BY_CZ  = 4'd0;
  localparam logic [STEP_W-1:0] ST_BZ_CY  = 4'd1;
  localparam logic [STEP_W-1:0] ST_BX_CZ  = 4'd2;
  localparam logic [STEP_W-1:0] ST_BZ_CX  = 4'd3;
  localparam logic [STEP_W-1:0] ST_BX_CY  = 4'd4;
  localparam logic [STEP_W-1:0] ST_BY_CX  = 4'd5;
  localparam logic [STEP_W-1:0] ST_M1L_AX = 4'd6;
  localparam logic [STEP_W-1:0] ST_M1H_AX = 4'd7;
  localparam logic [STEP_W-1:0] ST_M2L_AY = 4'd8;
  localparam logic [STEP_W-1:0] ST_M2H_AY = 4'd9;
  localparam logic [STEP_W-1:0] ST_M3L_AZ = 4'd10;
  localparam logic [STEP_W-1:0] ST_M3H_AZ = 4'd11;

  // Takes the low COORD_BITS of a sign-extended input coordinate.
  function automatic logic [COORD_BITS-1:0] coord_fit(input logic [IN_COORD_W-1:0] raw);
    logic [IN_COORD_W+32-1:0] ext;
    ext = {{32{raw[IN_COORD_W-1]}}, raw};
    return ext[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff_of(input logic [COORD_BITS-1:0] cur,
                                                       input logic [COORD_BITS-1:0] base);
    logic signed [DIFF_W-1:0] c;
    logic signed [DIFF_W-1:0] b;
    c = {cur[COORD_BITS-1], cur};
    b = {base[COORD_BITS-1], base};
    return c - b;
  endfunction

  function automatic logic index_ok(input logic [CORNER_W-1:0] corner,
                                    input logic [VCOUNT_W-1:0] vcount);
    logic [CORNER_W-1:0] vc_ext;
    logic [CORNER_W-1:0] depth;
    vc_ext = CORNER_W'(vcount);
    depth  = CORNER_W'(VERTEX_DEPTH);
    return !corner[CORNER_W-1] && (corner < vc_ext) && (corner < depth);
  endfunction

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] c);
    return (c == {TALLY_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== hdl/tetra_mesh_volume_check_unit.sv =====
// Tetrahedral mesh volume checker.
// Input channel (in_valid_i/in_ready_o) carries one word per item. A vertex
// write word stores three coordinates in the vertex memory in the cycle it
// is accepted; the next word can follow in the next cycle. A check word
// gives four corner indices and yields one result word on the output channel
// (out_valid_o/out_ready_i): class, saturating tallies, sticky index error
// flag and overall verdict.
// A check with a bad index goes straight to the classify state without reading the vertex memory.
// A good check runs through four reads of the single-port vertex memory
// (one per cycle, each read registered), twelve products through the one
// shared multiplier, an accumulate state that adds in the last product
// and a classify state. The block takes a new word as soon as the result
// has moved into the output register, so one check is in work at a time.
// A result that the receiver has not taken stays in the output register and
// the next word is still accepted; a finished check waits in its classify
// cycle until the output register is free.
// Reset clears the tallies, the error flag, the configuration registers
// (vertex count 0, degenerate limit 1) and the control state. The vertex
// memory is not cleared; every vertex must be written before it is used.
// Config writes act at once; the user, not the block, ensures they are made while idle.
module tetra_mesh_volume_check_unit
  import tmvc_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [SLOT_W-1:0]             vertex_slot_i,
  input  logic signed [IN_COORD_W-1:0]  coord_x_i,
  input  logic signed [IN_COORD_W-1:0]  coord_y_i,
  input  logic signed [IN_COORD_W-1:0]  coord_z_i,
  input  logic signed [CORNER_W-1:0]    corner_a_i,
  input  logic signed [CORNER_W-1:0]    corner_b_i,
  input  logic signed [CORNER_W-1:0]    corner_c_i,
  input  logic signed [CORNER_W-1:0]    corner_d_i,
  input  logic                          clear_tallies_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    tet_class_o,
  output logic [TALLY_W-1:0]            degenerate_tally_o,
  output logic [TALLY_W-1:0]            inverted_tally_o,
  output logic [TALLY_W-1:0]            checked_tally_o,
  output logic                          index_error_seen_o,
  output logic                          mesh_ok_o,

  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD_A  = 9'b000000010,
    S_RD_B  = 9'b000000100,
    S_RD_C  = 9'b000001000,
    S_RD_D  = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_FLUSH = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [VCOUNT_W-1:0] vcount_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic [TALLY_W-1:0] deg_cnt_q, inv_cnt_q, chk_cnt_q;
  logic               err_q;

  logic in_fire, out_free, done_fire;
  logic all_ok;

  // Vertex memory, one entry holds {z, y, x}.
  logic [VERT_W-1:0] vertex_mem [VERTEX_DEPTH];
  logic [VERT_W-1:0] rd_q;
  logic [VERT_W-1:0] wr_data;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [CORNER_W-1:0] slot_ext;

  logic [ADDR_W-1:0] idx_a_q, idx_b_q, idx_c_q, idx_d_q;
  logic              bad_q;
  logic [VERT_W-1:0] p0_q;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [DIFF_W-1:0] e1x_q, e1y_q, e1z_q;
  logic signed [DIFF_W-1:0] e2x_q, e2y_q, e2z_q;
  logic signed [DIFF_W-1:0] e3x_q, e3y_q, e3z_q;

  logic signed [OPA_W-1:0]   opa;
  logic signed [DIFF_W-1:0]  opb;
  logic signed [PROD_W-1:0]  prod_q;
  logic [STEP_W-1:0]         pstep_q;
  logic                      pvalid_q;
  logic signed [MINOR_W-1:0] m1_q, m2_q, m3_q;
  logic signed [VOL_W-1:0]   vol_q;
  logic signed [VOL_W-1:0]   prod_lo_ext, prod_hi_ext;

  logic               vol_neg;
  logic [VOL_W-1:0]   vol_mag;
  logic               is_degen;
  tet_class_e         cls_d;
  logic [TALLY_W-1:0] deg_nxt, inv_nxt, chk_nxt;
  logic               err_nxt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign done_fire  = (state_q == S_DONE) && out_free;

  assign all_ok = index_ok(corner_a_i, vcount_q) && index_ok(corner_b_i, vcount_q) &&
                  index_ok(corner_c_i, vcount_q) && index_ok(corner_d_i, vcount_q);

  // Control sequence.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (operation_i == OP_CHECK)) begin
          state_d = all_ok ? S_RD_A : S_DONE;
        end
      end
      S_RD_A: state_d = S_RD_B;
      S_RD_B: state_d = S_RD_C;
      S_RD_C: state_d = S_RD_D;
      S_RD_D: state_d = S_LOAD;
      S_LOAD: begin
        state_d = S_MUL;
        step_d  = ST_BY_CZ;
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == ST_M3H_AZ) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port: the write slot while idle, the corners during the reads.
  assign slot_ext = CORNER_W'(vertex_slot_i);
  assign mem_we   = in_fire && (operation_i == OP_WRITE) &&
                    (slot_ext < CORNER_W'(VERTEX_DEPTH));
  assign wr_data  = {coord_fit(coord_z_i), coord_fit(coord_y_i), coord_fit(coord_x_i)};

  always_comb begin
    unique case (state_q)
      S_RD_A:  mem_addr = idx_a_q;
      S_RD_B:  mem_addr = idx_b_q;
      S_RD_C:  mem_addr = idx_c_q;
      S_RD_D:  mem_addr = idx_d_q;
      default: mem_addr = slot_ext[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vertex_mem[mem_addr] <= wr_data;
    end
    rd_q <= vertex_mem[mem_addr];
  end

  // Edge vectors from corner a, formed as each read returns.
  assign dx = diff_of(rd_q[COORD_BITS-1:0], p0_q[COORD_BITS-1:0]);
  assign dy = diff_of(rd_q[2*COORD_BITS-1:COORD_BITS], p0_q[2*COORD_BITS-1:COORD_BITS]);
  assign dz = diff_of(rd_q[3*COORD_BITS-1:2*COORD_BITS], p0_q[3*COORD_BITS-1:2*COORD_BITS]);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step_q)
      ST_BY_CZ: begin
        opa = {{(OPA_W-DIFF_W){e2y_q[DIFF_W-1]}}, e2y_q};
        opb = e3z_q;
      end
      ST_BZ_CY: begin
        opa = {{(OPA_W-DIFF_W){e2z_q[DIFF_W-1]}}, e2z_q};
        opb = e3y_q;
      end
      ST_BX_CZ: begin
        opa = {{(OPA_W-DIFF_W){e2x_q[DIFF_W-1]}}, e2x_q};
        opb = e3z_q;
      end
      ST_BZ_CX: begin
        opa = {{(OPA_W-DIFF_W){e2z_q[DIFF_W-1]}}, e2z_q};
        opb = e3x_q;
      end
      ST_BX_CY: begin
        opa = {{(OPA_W-DIFF_W){e2x_q[DIFF_W-1]}}, e2x_q};
        opb = e3y_q;
      end
      ST_BY_CX: begin
        opa = {{(OPA_W-DIFF_W){e2y_q[DIFF_W-1]}}, e2y_q};
        opb = e3x_q;
      end
      ST_M1L_AX: begin
        opa = {1'b0, m1_q[LO_W-1:0]};
        opb = e1x_q;
      end
      ST_M1H_AX: begin
        opa = {{(OPA_W-DIFF_W){m1_q[MINOR_W-1]}}, m1_q[MINOR_W-1:LO_W]};
        opb = e1x_q;
      end
      ST_M2L_AY: begin
        opa = {1'b0, m2_q[LO_W-1:0]};
        opb = e1y_q;
      end
      ST_M2H_AY: begin
        opa = {{(OPA_W-DIFF_W){m2_q[MINOR_W-1]}}, m2_q[MINOR_W-1:LO_W]};
        opb = e1y_q;
      end
      ST_M3L_AZ: begin
        opa = {1'b0, m3_q[LO_W-1:0]};
        opb = e1z_q;
      end
      ST_M3H_AZ: begin
        opa = {{(OPA_W-DIFF_W){m3_q[MINOR_W-1]}}, m3_q[MINOR_W-1:LO_W]};
        opb = e1z_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_lo_ext = {{(VOL_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign prod_hi_ext = {prod_q, {LO_W{1'b0}}};

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_a_q <= corner_a_i[ADDR_W-1:0];
      idx_b_q <= corner_b_i[ADDR_W-1:0];
      idx_c_q <= corner_c_i[ADDR_W-1:0];
      idx_d_q <= corner_d_i[ADDR_W-1:0];
      bad_q   <= !all_ok;
    end
    if (state_q == S_RD_B) begin
      p0_q <= rd_q;
    end
    if (state_q == S_RD_C) begin
      e1x_q <= dx;
      e1y_q <= dy;
      e1z_q <= dz;
    end
    if (state_q == S_RD_D) begin
      e2x_q <= dx;
      e2y_q <= dy;
      e2z_q <= dz;
    end
    if (state_q == S_LOAD) begin
      e3x_q <= dx;
      e3y_q <= dy;
      e3z_q <= dz;
    end

    prod_q  <= opa * opb;
    pstep_q <= step_q;

    if (state_q == S_LOAD) begin
      m1_q  <= '0;
      m2_q  <= '0;
      m3_q  <= '0;
      vol_q <= '0;
    end else if (pvalid_q) begin
      case (pstep_q) inside
        ST_BY_CZ:                       m1_q  <= m1_q + prod_q[MINOR_W-1:0];
        ST_BZ_CY:                       m1_q  <= m1_q - prod_q[MINOR_W-1:0];
        ST_BX_CZ:                       m2_q  <= m2_q + prod_q[MINOR_W-1:0];
        ST_BZ_CX:                       m2_q  <= m2_q - prod_q[MINOR_W-1:0];
        ST_BX_CY:                       m3_q  <= m3_q + prod_q[MINOR_W-1:0];
        ST_BY_CX:                       m3_q  <= m3_q - prod_q[MINOR_W-1:0];
        ST_M1L_AX, ST_M3L_AZ:           vol_q <= vol_q + prod_lo_ext;
        ST_M1H_AX, ST_M3H_AZ:           vol_q <= vol_q + prod_hi_ext;
        ST_M2L_AY:                      vol_q <= vol_q - prod_lo_ext;
        ST_M2H_AY:                      vol_q <= vol_q - prod_hi_ext;
        default:                        vol_q <= vol_q;
      endcase
    end
  end

  // Classification and tally update.
  assign vol_neg  = vol_q[VOL_W-1];
  assign vol_mag  = vol_neg ? (~vol_q + 1'b1) : vol_q;
  assign is_degen = CMP_W'(vol_mag) < CMP_W'(limit_q);

  always_comb begin
    if (bad_q) begin
      cls_d = CLS_BAD;
    end else if (is_degen) begin
      cls_d = CLS_DEGEN;
    end else if (vol_neg) begin
      cls_d = CLS_INV;
    end else begin
      cls_d = CLS_OK;
    end
  end

  assign deg_nxt = (cls_d == CLS_DEGEN) ? sat_inc(deg_cnt_q) : deg_cnt_q;
  assign inv_nxt = (cls_d == CLS_INV) ? sat_inc(inv_cnt_q) : inv_cnt_q;
  assign chk_nxt = sat_inc(chk_cnt_q);
  assign err_nxt = err_q || (cls_d == CLS_BAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pvalid_q    <= 1'b0;
      vcount_q    <= '0;
      limit_q     <= LIMIT_W'(1);
      deg_cnt_q   <= '0;
      inv_cnt_q   <= '0;
      chk_cnt_q   <= '0;
      err_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pvalid_q <= (state_q == S_MUL);

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_VERTEX_COUNT: vcount_q <= cfg_data_i[VCOUNT_W-1:0];
          CFG_DEGEN_LIMIT:  limit_q  <= cfg_data_i[LIMIT_W-1:0];
          default:          vcount_q <= vcount_q;
        endcase
      end

      if (in_fire && clear_tallies_i) begin
        deg_cnt_q <= '0;
        inv_cnt_q <= '0;
        chk_cnt_q <= '0;
        err_q     <= 1'b0;
      end else if (done_fire) begin
        deg_cnt_q <= deg_nxt;
        inv_cnt_q <= inv_nxt;
        chk_cnt_q <= chk_nxt;
        err_q     <= err_nxt;
      end

      if (done_fire) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      tet_class_o        <= cls_d;
      degenerate_tally_o <= deg_nxt;
      inverted_tally_o   <= inv_nxt;
      checked_tally_o    <= chk_nxt;
      index_error_seen_o <= err_nxt;
      mesh_ok_o          <= (deg_nxt == '0) && (inv_nxt == '0) && !err_nxt;
    end
  end

  a_done_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> out_valid_o)
    else $error("finished check did not reach the output register");

  a_idle_no_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pvalid_q)
    else $error("product pending while accepting a new word");

  a_checked_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && clear_tallies_i) |=> (chk_cnt_q >= $past(chk_cnt_q)))
    else $error("checked tally went down without a clear");

  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mesh_ok_o == ((degenerate_tally_o == '0) &&
                                   (inverted_tally_o == '0) && !index_error_seen_o)))
    else $error("verdict disagrees with tallies");

endmodule

// ===== test/tetra_mesh_volume_check_unit_test.sv =====
module tetra_mesh_volume_check_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmvc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 275;
  localparam int C_MAX = 8388607;
  localparam int C_MIN = -8388608;

  typedef struct {
    logic                         op;
    logic [SLOT_W-1:0]            slot;
    logic signed [IN_COORD_W-1:0] x;
    logic signed [IN_COORD_W-1:0] y;
    logic signed [IN_COORD_W-1:0] z;
    logic signed [CORNER_W-1:0]   a;
    logic signed [CORNER_W-1:0]   b;
    logic signed [CORNER_W-1:0]   c;
    logic signed [CORNER_W-1:0]   d;
    logic                         clr;
  } mesh_word_t;

  typedef struct {
    tet_class_e         cls;
    logic [TALLY_W-1:0] degen;
    logic [TALLY_W-1:0] inv;
    logic [TALLY_W-1:0] checked;
    logic               err;
    logic               ok;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         operation = OP_WRITE;
  logic [SLOT_W-1:0]            vertex_slot = '0;
  logic signed [IN_COORD_W-1:0] coord_x = '0;
  logic signed [IN_COORD_W-1:0] coord_y = '0;
  logic signed [IN_COORD_W-1:0] coord_z = '0;
  logic signed [CORNER_W-1:0]   corner_a = '0;
  logic signed [CORNER_W-1:0]   corner_b = '0;
  logic signed [CORNER_W-1:0]   corner_c = '0;
  logic signed [CORNER_W-1:0]   corner_d = '0;
  logic                         clear_tallies = 1'b0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   tet_class;
  logic [TALLY_W-1:0]           degenerate_tally;
  logic [TALLY_W-1:0]           inverted_tally;
  logic [TALLY_W-1:0]           checked_tally;
  logic                         index_error_seen;
  logic                         mesh_ok;

  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  // Mirror of the block: vertex memory, tallies, flag and registers.
  logic signed [COORD_BITS-1:0] vert_x [VERTEX_DEPTH];
  logic signed [COORD_BITS-1:0] vert_y [VERTEX_DEPTH];
  logic signed [COORD_BITS-1:0] vert_z [VERTEX_DEPTH];
  logic [TALLY_W-1:0] degen_count = '0;
  logic [TALLY_W-1:0] inv_count = '0;
  logic [TALLY_W-1:0] check_count = '0;
  logic               index_error = 1'b0;
  logic [VCOUNT_W-1:0] vcount_reg = '0;
  logic [LIMIT_W-1:0]  limit_reg = LIMIT_W'(1);

  mesh_word_t words_to_send [$];
  verdict_t   verdicts_due [$];
  mesh_word_t word_on_bus;
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;
  int unsigned recv_stall = 0;
  bit          recv_burst = 1'b0;

  // Stimulus side bookkeeping: which slots hold a vertex, and which of
  // those are legal corners under the current vertex count.
  bit slot_loaded [int];
  int loaded_pool [$];
  int index_span = 0;

  tetra_mesh_volume_check_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .vertex_slot_i      (vertex_slot),
    .coord_x_i          (coord_x),
    .coord_y_i          (coord_y),
    .coord_z_i          (coord_z),
    .corner_a_i         (corner_a),
    .corner_b_i         (corner_b),
    .corner_c_i         (corner_c),
    .corner_d_i         (corner_d),
    .clear_tallies_i    (clear_tallies),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .tet_class_o        (tet_class),
    .degenerate_tally_o (degenerate_tally),
    .inverted_tally_o   (inverted_tally),
    .checked_tally_o    (checked_tally),
    .index_error_seen_o (index_error_seen),
    .mesh_ok_o          (mesh_ok),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [TALLY_W-1:0] count_up(input logic [TALLY_W-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  // Updates the mirror for one accepted word and records the verdict that a
  // check word must produce.
  function automatic void classify_word(input mesh_word_t w);
    logic signed [CORNER_W-1:0] corners [4];
    int ix [4];
    int k;
    logic all_good;
    longint x0, y0, z0, ax, ay, az, bx, by, bz, cx, cy, cz, m1, m2, m3;
    logic signed [127:0] w1, w2, w3, vol;
    logic [127:0] mag;
    verdict_t v;
    if (w.clr) begin
      degen_count = '0;
      inv_count = '0;
      check_count = '0;
      index_error = 1'b0;
    end
    if (w.op == OP_WRITE) begin
      vert_x[w.slot] = w.x[COORD_BITS-1:0];
      vert_y[w.slot] = w.y[COORD_BITS-1:0];
      vert_z[w.slot] = w.z[COORD_BITS-1:0];
    end else begin
      corners = '{w.a, w.b, w.c, w.d};
      all_good = 1'b1;
      for (k = 0; k < 4; k++) begin
        if (corners[k] < 0 || corners[k] >= longint'(vcount_reg) ||
            corners[k] >= longint'(VERTEX_DEPTH))
          all_good = 1'b0;
        else
          ix[k] = corners[k];
      end
      check_count = count_up(check_count);
      v.cls = CLS_OK;
      if (!all_good) begin
        v.cls = CLS_BAD;
        index_error = 1'b1;
      end else begin
        x0 = vert_x[ix[0]];
        y0 = vert_y[ix[0]];
        z0 = vert_z[ix[0]];
        ax = vert_x[ix[1]] - x0;
        ay = vert_y[ix[1]] - y0;
        az = vert_z[ix[1]] - z0;
        bx = vert_x[ix[2]] - x0;
        by = vert_y[ix[2]] - y0;
        bz = vert_z[ix[2]] - z0;
        cx = vert_x[ix[3]] - x0;
        cy = vert_y[ix[3]] - y0;
        cz = vert_z[ix[3]] - z0;
        m1 = by * cz - bz * cy;
        m2 = bx * cz - bz * cx;
        m3 = bx * cy - by * cx;
        w1 = m1;
        w2 = m2;
        w3 = m3;
        // Exact triple product; it needs up to about 76 bits.
        vol = w1 * ax - w2 * ay + w3 * az;
        mag = vol[127] ? -vol : vol;
        if (mag < {66'd0, limit_reg}) begin
          v.cls = CLS_DEGEN;
          degen_count = count_up(degen_count);
        end else if (vol[127]) begin
          v.cls = CLS_INV;
          inv_count = count_up(inv_count);
        end
      end
      v.degen = degen_count;
      v.inv = inv_count;
      v.checked = check_count;
      v.err = index_error;
      v.ok = (degen_count == 0) && (inv_count == 0) && !index_error;
      verdicts_due.insert(verdicts_due.size(), v);
    end
  endfunction

  always @(posedge clk_i) begin : drive_words
    logic busy;
    busy = in_valid;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        classify_word(word_on_bus);
        words_accepted++;
        busy = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 5);
      end
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (words_to_send.size() != 0) begin
          word_on_bus = words_to_send.pop_front();
          operation <= word_on_bus.op;
          vertex_slot <= word_on_bus.slot;
          coord_x <= word_on_bus.x;
          coord_y <= word_on_bus.y;
          coord_z <= word_on_bus.z;
          corner_a <= word_on_bus.a;
          corner_b <= word_on_bus.b;
          corner_c <= word_on_bus.c;
          corner_d <= word_on_bus.d;
          clear_tallies <= word_on_bus.clr;
          busy = 1'b1;
        end
      end
    end
    in_valid <= busy;
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : take_results
    logic take;
    verdict_t want;
    take = out_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result word with nothing expected, class %0d, checked %0d",
                   $time, tet_class, checked_tally);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          report_field("tet_class", 64'(want.cls), 64'(tet_class));
          report_field("degenerate_tally", 64'(want.degen), 64'(degenerate_tally));
          report_field("inverted_tally", 64'(want.inv), 64'(inverted_tally));
          report_field("checked_tally", 64'(want.checked), 64'(checked_tally));
          report_field("index_error_seen", 64'(want.err), 64'(index_error_seen));
          report_field("mesh_ok", 64'(want.ok), 64'(mesh_ok));
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
        take = (recv_stall == 0);
      end else if (!take) begin
        if (recv_stall != 0) recv_stall--;
        take = (recv_stall == 0);
      end
    end
    out_ready <= take;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tetra_mesh_volume_check_unit verification failed");
      $finish;
    end
  end

  function automatic mesh_word_t noise_word(input logic op, input bit clr);
    mesh_word_t w;
    w.op = op;
    w.slot = SLOT_W'($urandom);
    w.x = IN_COORD_W'($urandom);
    w.y = IN_COORD_W'($urandom);
    w.z = IN_COORD_W'($urandom);
    w.a = $urandom;
    w.b = $urandom;
    w.c = $urandom;
    w.d = $urandom;
    w.clr = clr;
    return w;
  endfunction

  function automatic bit rare_clear();
    return $urandom_range(0, 31) == 0;
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic put_vertex(input int slot, input int x, input int y, input int z,
                            input bit clr);
    mesh_word_t w;
    w = noise_word(OP_WRITE, clr);
    w.slot = slot[SLOT_W-1:0];
    w.x = x[IN_COORD_W-1:0];
    w.y = y[IN_COORD_W-1:0];
    w.z = z[IN_COORD_W-1:0];
    words_to_send.insert(words_to_send.size(), w);
    words_queued++;
    if (!slot_loaded.exists(slot)) begin
      slot_loaded[slot] = 1'b1;
      if (slot < index_span) loaded_pool.insert(loaded_pool.size(), slot);
    end
  endtask

  task automatic put_check(input int a, input int b, input int c, input int d,
                           input bit clr);
    mesh_word_t w;
    w = noise_word(OP_CHECK, clr);
    w.a = a;
    w.b = b;
    w.c = c;
    w.d = d;
    words_to_send.insert(words_to_send.size(), w);
    words_queued++;
  endtask

  // A corner that is negative or not below the current legal range.
  function automatic int bad_corner();
    case ($urandom_range(0, 3))
      0: return $urandom | 32'h8000_0000;
      1: return index_span + $urandom_range(0, 2);
      2: return index_span + ($urandom % (32'h7FFF_FFFF - index_span));
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic int pool_pick();
    return loaded_pool[$urandom_range(0, loaded_pool.size() - 1)];
  endfunction

  task automatic add_tet_group();
    int pick, style, k, j, tmp, r, bx, by, bz;
    int slot [4];
    int px [4];
    int py [4];
    int pz [4];
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      // Load up to four vertices (a corner may reuse a loaded one), then check them in a shuffled corner order.
      style = $urandom_range(0, 3);
      r = (style == 1) ? 4096 : (style == 2) ? 3 : 1048576;
      bx = spread(2097152);
      by = spread(2097152);
      bz = spread(2097152);
      for (k = 0; k < 4; k++) begin
        if (style == 0) begin
          px[k] = $urandom;
          py[k] = $urandom;
          pz[k] = $urandom;
        end else begin
          px[k] = bx + spread(r);
          py[k] = by + spread(r);
          pz[k] = bz + spread(r);
        end
      end
      // Flat tetrahedra: a parallelogram corner, or a repeated point.
      if (style == 3) begin
        if ($urandom_range(0, 1)) begin
          px[3] = px[1] + px[2] - px[0];
          py[3] = py[1] + py[2] - py[0];
          pz[3] = pz[1] + pz[2] - pz[0];
        end else begin
          px[3] = px[1];
          py[3] = py[1];
          pz[3] = pz[1];
        end
      end
      for (k = 0; k < 4; k++) begin
        if (loaded_pool.size() != 0 && $urandom_range(0, 3) == 0) begin
          slot[k] = pool_pick();
        end else begin
          slot[k] = (index_span > 0) ? $urandom_range(0, index_span - 1)
                                     : $urandom_range(0, VERTEX_DEPTH - 1);
          put_vertex(slot[k], px[k], py[k], pz[k], rare_clear());
        end
      end
      for (k = 3; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = slot[k];
        slot[k] = slot[j];
        slot[j] = tmp;
      end
      put_check(slot[0], slot[1], slot[2], slot[3], rare_clear());
    end else if (pick <= 7 && loaded_pool.size() != 0) begin
      put_check(pool_pick(), pool_pick(), pool_pick(), pool_pick(), rare_clear());
    end else if (pick <= 8) begin
      // At least one corner out of range; the rest point at loaded vertices or are out of range too.
      k = $urandom_range(0, 3);
      for (j = 0; j < 4; j++)
        slot[j] = (j == k || loaded_pool.size() == 0 || $urandom_range(0, 3) == 0)
                  ? bad_corner() : pool_pick();
      put_check(slot[0], slot[1], slot[2], slot[3], rare_clear());
    end else begin
      put_vertex($urandom_range(0, VERTEX_DEPTH - 1), $urandom, $urandom, $urandom,
                 rare_clear());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_VERTEX_COUNT)
      vcount_reg = data[VCOUNT_W-1:0];
    else
      limit_reg = data[LIMIT_W-1:0];
  endtask

  task automatic refresh_pool();
    index_span = (vcount_reg > VERTEX_DEPTH) ? VERTEX_DEPTH : vcount_reg;
    loaded_pool.delete();
    foreach (slot_loaded[s])
      if (s < index_span) loaded_pool.insert(loaded_pool.size(), s);
  endtask

  // Waits until every word is taken and every result has come back, then
  // lets the block settle.
  task automatic drain();
    while (words_accepted != words_queued || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : run_test
    logic [VCOUNT_W-1:0] vc;
    logic [LIMIT_W-1:0] lim;
    logic [CFG_DATA_W-1:0] data;
    int p, goal;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the vertex count is zero, so every corner is out of range.
    put_check(0, 0, 0, 0, 1'b0);
    put_vertex(0, 0, 0, 0, 1'b1);
    drain();
    write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(VERTEX_DEPTH));
    write_reg(CFG_DEGEN_LIMIT, CFG_DATA_W'(1));
    refresh_pool();

    put_vertex(1, C_MAX, 0, 0, 1'b0);
    put_vertex(2, 0, C_MAX, 0, 1'b0);
    put_vertex(3, 0, 0, C_MAX, 1'b0);
    put_check(0, 1, 2, 3, 1'b0);
    put_check(0, 2, 1, 3, 1'b0);
    put_check(0, 0, 1, 2, 1'b0);
    put_vertex(VERTEX_DEPTH - 1, C_MIN, C_MIN, C_MIN, 1'b0);
    put_vertex(4, C_MAX, C_MIN, C_MIN, 1'b0);
    put_vertex(5, C_MIN, C_MAX, C_MIN, 1'b0);
    put_vertex(6, C_MIN, C_MIN, C_MAX, 1'b0);
    put_check(VERTEX_DEPTH - 1, 4, 5, 6, 1'b0);
    put_check(VERTEX_DEPTH - 1, 5, 4, 6, 1'b0);
    // Unit volume sits exactly at a limit of one, so it is not degenerate.
    put_vertex(7, 1, 0, 0, 1'b0);
    put_vertex(8, 0, 1, 0, 1'b0);
    put_vertex(9, 0, 0, 1, 1'b0);
    put_check(0, 7, 8, 9, 1'b0);
    put_check(0, 8, 7, 9, 1'b0);
    put_check(-1, 1, 2, 3, 1'b0);
    put_check(0, VERTEX_DEPTH, 2, 3, 1'b0);
    put_check(0, 1, 32'h7FFF_FFFF, 3, 1'b0);
    put_check(0, 1, 2, 32'h8000_0000, 1'b1);
    put_check(1, 2, 3, 0, 1'b0);

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin vc = VCOUNT_W'(VERTEX_DEPTH); lim = '0; end
        1: begin vc = VCOUNT_W'($urandom_range(2, 64)); lim = LIMIT_W'(2); end
        2: begin vc = '1; lim = '1; end
        3: begin
          vc = VCOUNT_W'($urandom_range(0, VERTEX_DEPTH));
          lim = LIMIT_W'({$urandom, $urandom});
        end
        4: begin
          vc = VCOUNT_W'(VERTEX_DEPTH);
          lim = LIMIT_W'({$urandom_range(0, 3), $urandom});
        end
        default: begin vc = VCOUNT_W'(1); lim = LIMIT_W'(1); end
      endcase
      // Bits above the vertex count field are junk that the block drops.
      data = p[0] ? CFG_DATA_W'({$urandom, $urandom}) : '0;
      data[VCOUNT_W-1:0] = vc;
      write_reg(CFG_VERTEX_COUNT, data);
      write_reg(CFG_DEGEN_LIMIT, lim);
      refresh_pool();
      goal = words_queued + PHASE_WORDS;
      while (words_queued < goal) add_tet_group();
    end
    drain();

    if (fail_count == 0 && verdicts_due.size() == 0)
      $display("tetra_mesh_volume_check_unit verification clean");
    else
      $display("tetra_mesh_volume_check_unit verification failed");
    $finish;
  end

endmodule
